>>> rtl/core/dte_pkg.sv
// types, constants and lookup functions for the date to epoch day converter
package dte_pkg;

    localparam int unsigned YearW  = 12;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned DaysW  = 19;
    localparam int unsigned WdayW  = 3;
    localparam int unsigned DoyW   = 9;
    localparam int unsigned YoeW   = 9;
    localparam int unsigned DoeW   = 18;
    localparam int unsigned BaseW  = 20;

    localparam logic [YearW-1:0] YearMin = 12'd1600;
    localparam logic [YearW-1:0] YearMax = 12'd2500;

    localparam logic [MonthW-1:0] MonJan = 4'd1;
    localparam logic [MonthW-1:0] MonFeb = 4'd2;
    localparam logic [MonthW-1:0] MonMar = 4'd3;
    localparam logic [MonthW-1:0] MonApr = 4'd4;
    localparam logic [MonthW-1:0] MonMay = 4'd5;
    localparam logic [MonthW-1:0] MonJun = 4'd6;
    localparam logic [MonthW-1:0] MonJul = 4'd7;
    localparam logic [MonthW-1:0] MonAug = 4'd8;
    localparam logic [MonthW-1:0] MonSep = 4'd9;
    localparam logic [MonthW-1:0] MonOct = 4'd10;
    localparam logic [MonthW-1:0] MonNov = 4'd11;
    localparam logic [MonthW-1:0] MonDec = 4'd12;

    // era codes: 400-year era index 3 to 6
    typedef logic [1:0] t_era;
    localparam t_era Era3 = 2'd0;
    localparam t_era Era4 = 2'd1;
    localparam t_era Era5 = 2'd2;
    localparam t_era Era6 = 2'd3;

    // keeps the day count positive for the mod 7 reduction, multiple of 7
    localparam logic [BaseW-1:0] WdayBias = 20'd140000;

    // days from march 1 to the first of the month
    function automatic logic [DoyW-1:0] month_offset(input logic [MonthW-1:0] m);
        logic [DoyW-1:0] r;
        case (m)
            MonMar:  r = 9'd0;
            MonApr:  r = 9'd31;
            MonMay:  r = 9'd61;
            MonJun:  r = 9'd92;
            MonJul:  r = 9'd122;
            MonAug:  r = 9'd153;
            MonSep:  r = 9'd184;
            MonOct:  r = 9'd214;
            MonNov:  r = 9'd245;
            MonDec:  r = 9'd275;
            MonJan:  r = 9'd306;
            MonFeb:  r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // first year of the era
    function automatic logic [YearW-1:0] era_start(input t_era e);
        logic [YearW-1:0] r;
        case (e)
            Era3:    r = 12'd1200;
            Era4:    r = 12'd1600;
            Era5:    r = 12'd2000;
            Era6:    r = 12'd2400;
            default: r = 12'd0;
        endcase
        return r;
    endfunction

    // era * 146097 - 719468
    function automatic logic signed [BaseW-1:0] era_base(input t_era e);
        logic signed [BaseW-1:0] r;
        case (e)
            Era3:    r = -20'sd281177;
            Era4:    r = -20'sd135080;
            Era5:    r = 20'sd11017;
            Era6:    r = 20'sd157114;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/date_to_epoch_day_and_weekday.sv
// gregorian date to signed day count from 1970-01-01 and weekday, four-stage pipeline
//
//  channel  | valid    | stall    | fields
//  ---------+----------+----------+----------------------------------------
//  date in  | i_valid  | o_stall  | i_year, i_month, i_day
//  result   | o_valid  | i_stall  | o_valid_res, o_epoch_days, o_weekday
//
//  one date per cycle while i_stall is low, the result is registered in each stage
//  stages: date checks and era split, day of era, day count, weekday by octal digit sum
//  each stage holds its beat only while the next one is full and stalled
//  o_stall follows i_stall combinationally through the stage valid chain
//  reset clears the stage valid bits only
module date_to_epoch_day_and_weekday (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dte_pkg::YearW-1:0]     i_year,
    input  logic [dte_pkg::MonthW-1:0]    i_month,
    input  logic [dte_pkg::DayW-1:0]      i_day,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_valid_res,
    output logic signed [dte_pkg::DaysW-1:0] o_epoch_days,
    output logic [dte_pkg::WdayW-1:0]     o_weekday
);
    import dte_pkg::*;

    logic rdy1, rdy2, rdy3, rdy4;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic                r_ok1, r_ok2, r_ok3, r_ok4;
    t_era                r_era1, r_era2;
    logic [YoeW-1:0]     r_yoe1;
    logic [DoyW-1:0]     r_doy1;
    logic [DoeW-1:0]     r_doe2;
    logic signed [DaysW-1:0] r_days3, r_days4;
    logic [WdayW-1:0]    r_wd4;

    logic                n_ok1;
    t_era                n_era1;
    logic [YoeW-1:0]     n_yoe1;
    logic [DoyW-1:0]     n_doy1;
    logic [DoeW-1:0]     n_doe2;
    logic signed [DaysW-1:0] n_days3;
    logic [WdayW-1:0]    n_wd4;

    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    // stage 1: checks, shifted year, era and day of year
    logic             leap, yok, mok, dok;
    logic [DayW-1:0]  mlen;
    logic [YearW-1:0] yy;

    always_comb begin
        yok  = (i_year >= YearMin) && (i_year <= YearMax);
        mok  = i_month inside {[MonJan:MonDec]};
        leap = (i_year[1:0] == 2'b00) &&
               !(i_year inside {12'd1700, 12'd1800, 12'd1900, 12'd2100,
                                12'd2200, 12'd2300, 12'd2500});
        if (i_month inside {MonApr, MonJun, MonSep, MonNov}) begin
            mlen = 5'd30;
        end else if (i_month == MonFeb) begin
            mlen = leap ? 5'd29 : 5'd28;
        end else begin
            mlen = 5'd31;
        end
        dok   = (i_day != '0) && (i_day <= mlen);
        n_ok1 = yok && mok && dok;

        yy = (i_month <= MonFeb) ? i_year - 12'd1 : i_year;
        if (yy >= 12'd2400) begin
            n_era1 = Era6;
        end else if (yy >= 12'd2000) begin
            n_era1 = Era5;
        end else if (yy >= 12'd1600) begin
            n_era1 = Era4;
        end else begin
            n_era1 = Era3;
        end
        n_yoe1 = YoeW'(yy - era_start(n_era1));
        n_doy1 = month_offset(i_month) + DoyW'(i_day) - 9'd1;
    end

    // stage 2: day of era
    logic [1:0] cent;

    always_comb begin
        if (r_yoe1 >= 9'd300) begin
            cent = 2'd3;
        end else if (r_yoe1 >= 9'd200) begin
            cent = 2'd2;
        end else if (r_yoe1 >= 9'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
        n_doe2 = DoeW'(r_yoe1) * 18'd365 + DoeW'(r_yoe1 >> 2) - DoeW'(cent)
               + DoeW'(r_doy1);
    end

    // stage 3: signed day count
    logic signed [BaseW-1:0] days_w;

    always_comb begin
        days_w  = era_base(r_era2) + $signed({2'b00, r_doe2});
        n_days3 = r_ok2 ? days_w[DaysW-1:0] : '0;
    end

    // stage 4: weekday, 8 is 1 mod 7 so octal digits add up
    logic [BaseW-1:0] pos;
    logic [20:0]      pos21;
    logic [5:0]       dsum;
    logic [3:0]       dsum2;

    always_comb begin
        pos   = {r_days3[DaysW-1], r_days3} + WdayBias;
        pos21 = {2'b00, pos[DaysW-1:0]};
        dsum  = '0;
        for (int k = 0; k < 7; k++) begin
            dsum = dsum + 6'(pos21[3*k +: 3]);
        end
        dsum2 = 4'(dsum[2:0]) + 4'(dsum[5:3]);
        n_wd4 = (dsum2 >= 4'd7) ? WdayW'(dsum2 - 4'd7) : WdayW'(dsum2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ok1  <= n_ok1;
            r_era1 <= n_era1;
            r_yoe1 <= n_yoe1;
            r_doy1 <= n_doy1;
        end
        if (rdy2) begin
            r_ok2  <= r_ok1;
            r_era2 <= r_era1;
            r_doe2 <= n_doe2;
        end
        if (rdy3) begin
            r_ok3   <= r_ok2;
            r_days3 <= n_days3;
        end
        if (rdy4) begin
            r_ok4   <= r_ok3;
            r_days4 <= r_days3;
            r_wd4   <= n_wd4;
        end
    end

    assign o_valid      = r_v4;
    assign o_valid_res  = r_ok4;
    assign o_epoch_days = r_days4;
    assign o_weekday    = r_wd4;

endmodule

>>> rtl/core/dte_checker.sv
// port-level checks for the date to epoch day converter, bound to the top level
module dte_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [dte_pkg::YearW-1:0]     i_year,
    input logic [dte_pkg::MonthW-1:0]    i_month,
    input logic [dte_pkg::DayW-1:0]      i_day,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_valid_res,
    input logic signed [dte_pkg::DaysW-1:0] o_epoch_days,
    input logic [dte_pkg::WdayW-1:0]     o_weekday
);
    import dte_pkg::*;

    logic [20:0] in_bits;
    assign in_bits = {i_year, i_month, i_day};

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_valid_res) &&
            $stable(o_epoch_days) && $stable(o_weekday))
        else $error("stalled result beat changed");

    // rejected date carries zero count and weekday
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_epoch_days == '0 && o_weekday == '0)
        else $error("invalid date with nonzero fields");

    // weekday stays in range
    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_weekday <= 3'd6)
        else $error("weekday out of range");

    // an accepted input beat reaches the output when the output side keeps taking
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && in_bits == in_bits) ##1 !i_stall ##1 !i_stall ##1 !i_stall
            |=> o_valid)
        else $error("input beat did not reach the output in time");

    // nothing leaves right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

endmodule

bind date_to_epoch_day_and_weekday dte_checker u_dte_checker (.*);

>>> dv/tb_date_to_epoch_day_and_weekday.sv
// testbench for the date to epoch day and weekday converter, with scoreboard and predictor
`timescale 1ns / 100ps

module tb_date_to_epoch_day_and_weekday;
    import dte_pkg::*;

    localparam int RandomItems  = 1650;
    localparam int LongHold     = 90;
    localparam int DaysPerCycle = 146097;
    localparam int EpochOffset  = 719468;
    localparam int ReportLimit  = 10;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } t_date;

    typedef struct packed {
        logic                    valid_res;
        logic signed [DaysW-1:0] days;
        logic [WdayW-1:0]        wday;
    } t_conversion;

    class date_scoreboard;
        t_conversion conversions_due[$];
        int          errors = 0;
        int          checked = 0;
        int          accepted_dates = 0;
        int          rejected_dates = 0;

        static function int month_days(int y, int m);
            if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) return 30;
            if (m == MonFeb) begin
                if (y % 4 != 0) return 28;
                if (y % 100 != 0) return 29;
                return (y % 400 == 0) ? 29 : 28;
            end
            return 31;
        endfunction

        function t_conversion convert_date(t_date dt);
            int          y, m, d;
            int          adj_year, cycle, yr_in_cycle, shifted_month;
            int          day_of_year, day_of_cycle, count, wd;
            t_conversion r;
            y = dt.year;
            m = dt.month;
            d = dt.day;
            r = '0;
            if (y < YearMin || y > YearMax || m < MonJan || m > MonDec) return r;
            if (d < 1 || d > month_days(y, m)) return r;
            adj_year      = (m <= MonFeb) ? y - 1 : y;
            cycle         = adj_year / 400;
            yr_in_cycle   = adj_year - cycle * 400;
            shifted_month = (m > MonFeb) ? m - 3 : m + 9;
            day_of_year   = (153 * shifted_month + 2) / 5 + d - 1;
            day_of_cycle  = yr_in_cycle * 365 + yr_in_cycle / 4 - yr_in_cycle / 100 + day_of_year;
            count         = cycle * DaysPerCycle + day_of_cycle - EpochOffset;
            wd            = ((count % 7) + 7) % 7;
            r.valid_res   = 1'b1;
            r.days        = count[DaysW-1:0];
            r.wday        = wd[WdayW-1:0];
            return r;
        endfunction

        function void note_date(t_date dt);
            conversions_due.push_back(convert_date(dt));
        endfunction

        function void check_result(logic valid_res, logic signed [DaysW-1:0] days,
                                   logic [WdayW-1:0] wday);
            t_conversion want;
            if (conversions_due.size() == 0) begin
                if (errors < ReportLimit)
                    $display("unexpected result beat: valid_res %0b days %0d weekday %0d",
                             valid_res, days, wday);
                errors++;
                return;
            end
            want = conversions_due.pop_front();
            checked++;
            if (want.valid_res) accepted_dates++;
            else rejected_dates++;
            if (valid_res !== want.valid_res || days !== want.days || wday !== want.wday) begin
                if (errors < ReportLimit)
                    $display("mismatch at result %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                             checked, want.valid_res, want.days, want.wday,
                             valid_res, days, wday);
                errors++;
            end
        endfunction

        function int pending();
            return conversions_due.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [YearW-1:0]        i_year = '0;
    logic [MonthW-1:0]       i_month = '0;
    logic [DayW-1:0]         i_day = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_valid_res;
    logic signed [DaysW-1:0] o_epoch_days;
    logic [WdayW-1:0]        o_weekday;

    date_scoreboard sb = new();
    bit             stall_enable = 1'b0;
    bit             send_gaps = 1'b0;
    bit             hold_request = 1'b0;
    int             input_stall_cycles = 0;

    date_to_epoch_day_and_weekday uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_year       (i_year),
        .i_month      (i_month),
        .i_day        (i_day),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_valid_res  (o_valid_res),
        .o_epoch_days (o_epoch_days),
        .o_weekday    (o_weekday)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** date_to_epoch_day_and_weekday: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall) input_stall_cycles++;
            if (i_valid && !o_stall) sb.note_date('{i_year, i_month, i_day});
            if (o_valid && !i_stall) sb.check_result(o_valid_res, o_epoch_days, o_weekday);
        end
    end

    initial begin : result_side
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (LongHold) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (stall_enable && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                @(posedge i_clk);
            end
        end
    end

    task automatic send_date(input t_date dt);
        i_valid <= 1'b1;
        i_year  <= dt.year;
        i_month <= dt.month;
        i_day   <= dt.day;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic t_date random_date();
        t_date dt;
        int    sel, y, m, len;
        sel = $urandom_range(0, 99);
        y   = $urandom_range(YearMin, YearMax);
        m   = $urandom_range(MonJan, MonDec);
        len = date_scoreboard::month_days(y, m);
        if (sel < 70) begin
            dt = '{y, m, $urandom_range(1, len)};
        end else if (sel < 80) begin
            // last day of the month or one past it
            dt = '{y, m, len + $urandom_range(0, 1)};
        end else if (sel < 86) begin
            // february end on century years
            dt = '{100 * $urandom_range(16, 25), MonFeb, $urandom_range(28, 30)};
        end else if (sel < 92) begin
            // around the year limits
            y  = $urandom_range(0, 1) ? YearMin - 2 + $urandom_range(0, 4)
                                      : YearMax - 2 + $urandom_range(0, 4);
            dt = '{y, m, $urandom_range(1, 28)};
        end else begin
            dt = 21'($urandom);
        end
        return dt;
    endfunction

    initial begin : date_side
        t_date directed[$];
        directed = '{
            '{1970, MonJan, 1},  '{1969, MonDec, 31}, '{1600, MonJan, 1},  '{2500, MonDec, 31},
            '{1599, MonDec, 31}, '{2501, MonJan, 1},  '{0, 0, 0},          '{4095, 15, 31},
            '{2000, MonFeb, 29}, '{1900, MonFeb, 29}, '{2100, MonFeb, 28}, '{1600, MonFeb, 29},
            '{2023, MonFeb, 29}, '{2024, MonFeb, 29}, '{2400, MonFeb, 29}, '{2500, MonFeb, 29},
            '{2021, MonApr, 31}, '{2021, MonApr, 30}, '{2021, 13, 1},      '{2021, 0, 10},
            '{2021, MonDec, 0},  '{2021, MonJan, 31}, '{1700, MonMar, 1},  '{2038, MonJan, 19}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_date(directed[k]);

        stall_enable = 1'b1;
        send_gaps    = 1'b1;
        for (int n = 0; n < RandomItems; n++) begin
            case (n)
                300: hold_request = 1'b1;
                600: begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.pending() != 0) @(posedge i_clk);
                end
                800: begin
                    stall_enable = 1'b0;
                    send_gaps    = 1'b0;
                end
                1000: begin
                    stall_enable = 1'b1;
                    send_gaps    = 1'b1;
                end
                1400: begin
                    stall_enable = 1'b0;
                    send_gaps    = 1'b0;
                end
                default: ;
            endcase
            send_date(random_date());
            if (send_gaps && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 18));
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("checked %0d result beats: %0d valid dates, %0d rejected dates",
                 sb.checked, sb.accepted_dates, sb.rejected_dates);
        $display("input held off for %0d cycles, including one long output hold of %0d cycles",
                 input_stall_cycles, LongHold);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** date_to_epoch_day_and_weekday: PASSED **");
        else
            $display("** date_to_epoch_day_and_weekday: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/dte_pkg.sv
rtl/core/date_to_epoch_day_and_weekday.sv
rtl/core/dte_checker.sv
dv/tb_date_to_epoch_day_and_weekday.sv
